### src/sfsc_pkg.sv
// ----------------------------------------------------------------------------
// sfsc_pkg
// Shared constants, types and arithmetic helpers for the size-field scale
// and clamp block.
// ----------------------------------------------------------------------------
package sfsc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
	localparam logic [31:0] SCALE_RESET = 32'h0001_0000;   // 1.0 in Q16.16
	// floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;
	// largest value whose tenfold still fits in 31 bits
	localparam logic [30:0] T10_LIMIT   = 31'd214748364;

	typedef enum logic [2:0] {
		REG_SCALE_FACTOR  = 3'd0,
		REG_USER_MIN_SIZE = 3'd1,
		REG_USER_MAX_SIZE = 3'd2,
		REG_MIN_IS_SET    = 3'd3,
		REG_MAX_IS_SET    = 3'd4
	} cfg_idx_t;

	// bound settings seen by the bounds sequencer
	typedef struct packed {
		logic [30:0] user_min;
		logic [30:0] user_max;
		logic        min_set;
		logic        max_set;
	} bnd_cfg_t;

	// bounds sequencer result
	typedef struct packed {
		logic        done;
		logic [30:0] lo;
		logic [30:0] hi;
	} bnd_res_t;

	function automatic logic [30:0] div10(input logic [30:0] x);
		logic [62:0] p;
		p = {32'd0, x} * {31'd0, DIV10_RECIP};
		return 31'(p >> DIV10_SHIFT);
	endfunction

	// saturating x * 10; x is non-negative
	function automatic logic [30:0] times_ten(input logic [30:0] x);
		logic [30:0] r;
		if (x > T10_LIMIT) begin
			r = SAT_POS[30:0];
		end else begin
			r = (x << 3) + (x << 1);
		end
		return r;
	endfunction

endpackage

### src/sfsc_ram.sv
// ----------------------------------------------------------------------------
// sfsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sfsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/sfsc_bounds.sv
// ----------------------------------------------------------------------------
// sfsc_bounds
// Derives the lower and upper clamp bounds from the run minimum/maximum and
// the user settings. One divide-by-ten (reciprocal multiply) step per
// cycle; start leads through DIV_MIN, DIV_REF, LO and HI to done.
// ----------------------------------------------------------------------------
module sfsc_bounds (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         rmin,
	input  logic [31:0]         rmax,
	input  sfsc_pkg::bnd_cfg_t  cfg,
	output sfsc_pkg::bnd_res_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_MIN,
		ST_DIV_REF,
		ST_LO,
		ST_HI
	} state_t;

	state_t      state_q;
	logic [30:0] div_q;
	logic [30:0] lo_q;
	logic [30:0] hi_q;
	logic [30:0] ref_q;
	logic        done_q;
	logic [30:0] ref_c;
	logic [30:0] t10_max;
	logic [30:0] t10_lo;

	// rmax never drops below zero, so its low 31 bits are the value
	assign ref_c   = cfg.max_set ? cfg.user_max : rmax[30:0];
	assign t10_max = sfsc_pkg::times_ten(rmax[30:0]);
	assign t10_lo  = sfsc_pkg::times_ten(lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV_MIN;
					end
				end
				ST_DIV_MIN: begin
					div_q   <= sfsc_pkg::div10(rmin[30:0]);
					state_q <= ST_DIV_REF;
				end
				ST_DIV_REF: begin
					// negative minimum floors to zero
					lo_q    <= rmin[31] ? 31'd0 : div_q;
					ref_q   <= ref_c;
					div_q   <= sfsc_pkg::div10(ref_c);
					state_q <= ST_LO;
				end
				ST_LO: begin
					if (cfg.min_set) begin
						lo_q <= cfg.user_min;
					end else if (lo_q > ref_q) begin
						lo_q <= div_q;
					end
					state_q <= ST_HI;
				end
				ST_HI: begin
					if (cfg.max_set) begin
						hi_q <= cfg.user_max;
					end else if (t10_max < lo_q) begin
						hi_q <= t10_lo;
					end else begin
						hi_q <= t10_max;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.done = done_q;
	assign res.lo   = lo_q;
	assign res.hi   = hi_q;

endmodule

### src/size_field_scale_and_clamp.sv
// ----------------------------------------------------------------------------
// size_field_scale_and_clamp
// Loads a run of Q16.16 sizes, scales valid ones, then replays them clamped.
// ----------------------------------------------------------------------------
// A run of up to 64 points streams in on s_*; s_tlast marks the final point.
// Each accepted point is registered, then stored: the accept cycle
// registers the scale product, the next cycle saturates it, writes it into
// the value RAM and updates the running min/max, so s_tready is low while
// a point is stored. A valid point with a non-positive size yields one
// error word (m_tuser high, m_tlast high, data zero); the remaining points
// of the run, final point included, are swallowed. Points beyond 64 are
// dropped. After the final point the bounds sequencer runs, then the stored
// values leave at one word per cycle while m_tready stays high, read from
// the registered RAM output and clamped on the way into the output
// register. No input is taken while bounds are computed or the run is being
// replayed. Configuration is written through cfg_we/cfg_index/cfg_wdata
// and must only change while the block is idle.
// ----------------------------------------------------------------------------
module size_field_scale_and_clamp (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] size_value
	input  logic        s_tuser,   // [0] point_valid
	input  logic        s_tlast,   // final_point
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] clamped_value, [62:32] bound_low,
	                               // [93:63] bound_high, [95:94] zero
	output logic        m_tuser,   // [0] status
	output logic        m_tlast    // end_of_run
);

	localparam int AW = sfsc_pkg::ADDR_W;
	localparam int CW = sfsc_pkg::CNT_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(sfsc_pkg::MAX_POINTS);

	typedef enum logic [2:0] {
		ST_LOAD,     // waiting for a point
		ST_STORE,    // saturate, write RAM, track min/max
		ST_ERR,      // post the error word
		ST_CALC,     // bounds sequencer running
		ST_EMIT      // replay stored values
	} state_t;

	// configuration registers
	logic [31:0] scale_q;
	logic [30:0] user_min_q;
	logic [30:0] user_max_q;
	logic        min_set_q;
	logic        max_set_q;

	// run state
	state_t          state_q;
	logic [31:0]     rmin_q;
	logic [31:0]     rmax_q;
	logic [CW-1:0]   cnt_q;
	logic            err_q;
	logic            bnd_start_q;
	logic [30:0]     lo_q;
	logic [30:0]     hi_q;

	// load pipeline
	logic [62:0]     prod_s1;
	logic [31:0]     raw_s1;
	logic            valid_s1;
	logic            fin_s1;

	// replay
	logic [CW-1:0]   rd_idx_q;
	logic [AW-1:0]   data_idx_q;
	logic            dv_q;

	// output register
	logic            m_tvalid_q;
	logic [95:0]     m_tdata_q;
	logic            m_tuser_q;
	logic            m_tlast_q;

	// combinational
	logic            in_acc;
	logic            bad_pt;
	logic [31:0]     sat_v;
	logic [31:0]     store_v;
	logic            out_free;
	logic            move;
	logic            issue;
	logic [31:0]     rdata;
	logic [31:0]     lo32;
	logic [31:0]     hi32;
	logic [31:0]     clamp_v;
	logic            mem_we;

	sfsc_pkg::bnd_cfg_t bnd_cfg;
	sfsc_pkg::bnd_res_t bnd_res;

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	// a valid point must be strictly positive
	assign bad_pt   = s_tuser && (s_tdata[31] || (s_tdata == 32'd0));

	// product >> 16, saturated to the largest positive Q16.16
	assign sat_v   = (|prod_s1[62:47]) ? sfsc_pkg::SAT_POS : {1'b0, prod_s1[46:16]};
	assign store_v = valid_s1 ? sat_v : raw_s1;
	assign mem_we  = (state_q == ST_STORE);

	// replay flow: RAM output register acts as a one-word skid stage
	assign out_free = !m_tvalid_q || m_tready;
	assign move     = (state_q == ST_EMIT) && dv_q && out_free;
	assign issue    = (state_q == ST_EMIT) && (rd_idx_q != cnt_q) && (!dv_q || move);

	// clamp: raise to lo first, then cap at hi (hi wins if lo > hi)
	assign lo32 = {1'b0, lo_q};
	assign hi32 = {1'b0, hi_q};
	always_comb begin
		clamp_v = rdata;
		if ($signed(clamp_v) < $signed(lo32)) begin
			clamp_v = lo32;
		end
		if ($signed(clamp_v) > $signed(hi32)) begin
			clamp_v = hi32;
		end
	end

	assign bnd_cfg.user_min = user_min_q;
	assign bnd_cfg.user_max = user_max_q;
	assign bnd_cfg.min_set  = min_set_q;
	assign bnd_cfg.max_set  = max_set_q;

	sfsc_ram #(
		.WIDTH(32),
		.DEPTH(sfsc_pkg::MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (store_v),
		.re    (issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	sfsc_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bnd_start_q),
		.rmin   (rmin_q),
		.rmax   (rmax_q),
		.cfg    (bnd_cfg),
		.res    (bnd_res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= sfsc_pkg::SCALE_RESET;
			user_min_q <= 31'd0;
			user_max_q <= 31'd0;
			min_set_q  <= 1'b0;
			max_set_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfsc_pkg::REG_SCALE_FACTOR:  scale_q    <= cfg_wdata;
				sfsc_pkg::REG_USER_MIN_SIZE: user_min_q <= cfg_wdata[30:0];
				sfsc_pkg::REG_USER_MAX_SIZE: user_max_q <= cfg_wdata[30:0];
				sfsc_pkg::REG_MIN_IS_SET:    min_set_q  <= cfg_wdata[0];
				sfsc_pkg::REG_MAX_IS_SET:    max_set_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// main sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rmin_q      <= sfsc_pkg::SAT_POS;
			rmax_q      <= 32'd0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			bnd_start_q <= 1'b0;
			rd_idx_q    <= '0;
			dv_q        <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			bnd_start_q <= 1'b0;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						raw_s1   <= s_tdata;
						valid_s1 <= s_tuser;
						fin_s1   <= s_tlast;
						prod_s1  <= {32'd0, s_tdata[30:0]} * {31'd0, scale_q};
						if (err_q) begin
							// swallow until the final point closes the run
							if (s_tlast) begin
								err_q  <= 1'b0;
								rmin_q <= sfsc_pkg::SAT_POS;
								rmax_q <= 32'd0;
								cnt_q  <= '0;
							end
						end else if (cnt_q == FULL_CNT) begin
							if (s_tlast) begin
								bnd_start_q <= 1'b1;
								state_q     <= ST_CALC;
							end
						end else if (bad_pt) begin
							state_q <= ST_ERR;
						end else begin
							state_q <= ST_STORE;
						end
					end
				end
				ST_STORE: begin
					cnt_q <= cnt_q + CW'(1);
					if ($signed(store_v) < $signed(rmin_q)) begin
						rmin_q <= store_v;
					end
					if ($signed(store_v) > $signed(rmax_q)) begin
						rmax_q <= store_v;
					end
					if (fin_s1) begin
						bnd_start_q <= 1'b1;
						state_q     <= ST_CALC;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= 96'd0;
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= 1'b1;
						if (fin_s1) begin
							rmin_q <= sfsc_pkg::SAT_POS;
							rmax_q <= 32'd0;
							cnt_q  <= '0;
						end else begin
							err_q <= 1'b1;
						end
						state_q <= ST_LOAD;
					end
				end
				ST_CALC: begin
					rd_idx_q <= '0;
					dv_q     <= 1'b0;
					if (bnd_res.done) begin
						lo_q    <= bnd_res.lo;
						hi_q    <= bnd_res.hi;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						rd_idx_q   <= rd_idx_q + CW'(1);
						data_idx_q <= rd_idx_q[AW-1:0];
						dv_q       <= 1'b1;
					end else if (move) begin
						dv_q <= 1'b0;
					end
					if (move) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, hi_q, lo_q, clamp_v};
						m_tuser_q  <= 1'b0;
						m_tlast_q  <= ((CW'(data_idx_q) + CW'(1)) == cnt_q);
					end
					if (!dv_q && (rd_idx_q == cnt_q)) begin
						// run replayed; back to reset run state
						rmin_q  <= sfsc_pkg::SAT_POS;
						rmax_q  <= 32'd0;
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

### src/sfsc_checker.sv
// ----------------------------------------------------------------------------
// sfsc_checker
// Port-level checks for the size-field scale and clamp block.
// ----------------------------------------------------------------------------
module sfsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// error word is a lone, zeroed, run-ending word
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == 96'd0))
		else $error("malformed error word");

	// clamped value is non-negative and never above the upper bound
	a_clamp_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[31] && (m_tdata[30:0] <= m_tdata[93:63]))
		else $error("clamped value outside upper bound");

	// padding bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[95:94] == 2'b00))
		else $error("output padding not zero");

endmodule

bind size_field_scale_and_clamp sfsc_checker u_sfsc_checker (.*);
